// ===== design/dcs_pkg.sv =====
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared types, codes and constants of the deadline callout scheduler.
// ----------------------------------------------------------------------------
package dcs_pkg;

    localparam int DEF_SLOTS     = 16;
    localparam int DEF_MAX_FIRES = 63;
    localparam int LATENCY_BINS  = 8;
    localparam int HIST_ENTRIES  = LATENCY_BINS + 1;
    localparam int IDX_W         = 8;

    localparam logic [19:0] MIN_INTERVAL_RESET = 20'd50;
    localparam logic [25:0] MAX_INTERVAL_RESET = 26'd50000000;

    localparam logic [2:0] CMD_SCHEDULE = 3'd0;
    localparam logic [2:0] CMD_CANCEL   = 3'd1;
    localparam logic [2:0] CMD_TICK     = 3'd2;
    localparam logic [2:0] CMD_QUERY    = 3'd3;
    localparam logic [2:0] CMD_READ_BIN = 3'd4;

    localparam logic [1:0] KIND_FIRE    = 2'd0;
    localparam logic [1:0] KIND_COMPARE = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_COUNT   = 2'd3;

    localparam logic [1:0] CFG_MIN_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_MAX_INTERVAL = 2'd1;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  slot;
        logic [63:0] deadline;
        logic [31:0] period;
        logic        notify;
        logic [63:0] now;
        logic [3:0]  bin;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [3:0]  fired_slot;
        logic        timer_rearmed;
        logic [25:0] next_delay;
        logic        entry_done;
        logic [31:0] bin_count;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_SETUP,
        WR_ENTER,
        WR_CANCEL,
        WR_EXPIRE
    } wr_op_t;

    typedef struct packed {
        wr_op_t             op;
        logic [IDX_W-1:0]   idx;
        logic [63:0]        deadline;
        logic [31:0]        period;
        logic               notify;
        logic [31:0]        stamp;
    } slot_wr_t;

    // best-so-far entry handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   idx;
        logic [63:0]        deadline;
        logic [31:0]        age;
        logic [31:0]        period;
        logic               notify;
    } cand_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DECIDE,
        ST_REARM,
        ST_REPORT,
        ST_BINRD
    } state_t;

    function automatic logic [3:0] latency_bin(input logic [15:0] lat);
        logic [15:0] bounds [LATENCY_BINS];
        logic [3:0]  b;
        bounds = '{16'd1, 16'd2, 16'd5, 16'd10, 16'd20, 16'd50, 16'd100, 16'd1000};
        b = 4'(LATENCY_BINS);
        for (int i = LATENCY_BINS - 1; i >= 0; i--)
        begin
            if (lat <= bounds[i])
            begin
                b = 4'(i);
            end
        end
        return b;
    endfunction

endpackage

// ===== design/dcs_slot_cell.sv =====
// ----------------------------------------------------------------------------
// dcs_slot_cell
// One timer slot: holds its entry and folds it into the passing head candidate.
// ----------------------------------------------------------------------------
module dcs_slot_cell
    import dcs_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  slot_wr_t    wr,
    input  logic [31:0] insert_count,
    input  cand_t       cand_in,
    output cand_t       cand_out,
    output logic        done
);

    logic        active_reg;
    logic        done_reg;
    logic [63:0] deadline_reg;
    logic [31:0] period_reg;
    logic        notify_reg;
    logic [31:0] stamp_reg;
    cand_t       cand_reg;
    cand_t       cand_next;
    logic        hit;
    logic [31:0] age;
    logic        take;

    assign hit = (wr.idx == IDX_W'(IDX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b1;
        end
        else if (hit)
        begin
            case (wr.op)
                WR_SETUP:  active_reg <= 1'b0;
                WR_ENTER:
                begin
                    active_reg <= 1'b1;
                    done_reg   <= 1'b0;
                end
                WR_CANCEL, WR_EXPIRE:
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            case (wr.op)
                WR_SETUP:
                begin
                    period_reg <= wr.period;
                    notify_reg <= wr.notify;
                end
                WR_ENTER:
                begin
                    deadline_reg <= wr.deadline;
                    stamp_reg    <= wr.stamp;
                end
                WR_CANCEL: period_reg <= 32'd0;
                default: ;
            endcase
        end
    end

    // earlier deadline wins, on a tie the older entry
    assign age  = insert_count - stamp_reg;
    assign take = active_reg && (!cand_in.valid || deadline_reg < cand_in.deadline ||
                  (deadline_reg == cand_in.deadline && age > cand_in.age));

    always_comb
    begin
        cand_next = cand_in;
        if (take)
        begin
            cand_next.valid    = 1'b1;
            cand_next.idx      = IDX_W'(IDX);
            cand_next.deadline = deadline_reg;
            cand_next.age      = age;
            cand_next.period   = period_reg;
            cand_next.notify   = notify_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
        end
    end

    assign cand_out = cand_reg;
    assign done     = done_reg;

endmodule

// ===== design/dcs_hist.sv =====
// ----------------------------------------------------------------------------
// dcs_hist
// Tick latency histogram: nine wrapping counters, one bump and one read port.
// ----------------------------------------------------------------------------
module dcs_hist
    import dcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        inc,
    input  logic [15:0] lat,
    input  logic [3:0]  rd_bin,
    output logic [31:0] rd_count
);

    logic [31:0] hist_reg [HIST_ENTRIES];
    logic [31:0] rd_count_reg;
    logic [3:0]  inc_bin;

    assign inc_bin = latency_bin(lat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_ENTRIES; i++)
            begin
                hist_reg[i] <= 32'd0;
            end
            rd_count_reg <= 32'd0;
        end
        else
        begin
            if (inc)
            begin
                hist_reg[inc_bin] <= hist_reg[inc_bin] + 32'd1;
            end
            if (32'(rd_bin) < HIST_ENTRIES)
            begin
                rd_count_reg <= hist_reg[rd_bin];
            end
            else
            begin
                rd_count_reg <= 32'd0;
            end
        end
    end

    assign rd_count = rd_count_reg;

endmodule

// ===== design/deadline_callout_scheduler.sv =====
// ----------------------------------------------------------------------------
// deadline_callout_scheduler
// Timer slot table with deadline ordering, periodic re-entry, fire results,
// compare delay reporting and a tick latency histogram.
// ----------------------------------------------------------------------------
// Cancel and unknown commands give no result beat; query and read bin give one.
// Schedule: head scan through the cell chain, then the rearm and report states when rearmed.
// Tick: after the histogram bump, every expiry waits for one full pass
//   of the head candidate down the slot cell chain (one cell per cycle).
// One item at a time: busy stays high until the item's last beat is issued.
// Result beats are single-cycle strobes; the receiver cannot stall.
// Reset (rst_n low, async): all slots inactive and done, histogram cleared,
//   intervals back to 50 us / 50 s, insert counter and baseline zero.
// ----------------------------------------------------------------------------
module deadline_callout_scheduler
    import dcs_pkg::*;
#(
    parameter int SLOTS     = DEF_SLOTS,
    parameter int MAX_FIRES = DEF_MAX_FIRES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [25:0] cfg_data,
    output logic        result_strobe,
    output out_item_t   result
);

    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SCW = $clog2(SLOTS + 1);
    localparam int FCW = $clog2(MAX_FIRES + 1);

    state_t          state_reg, state_next;
    in_item_t        item_reg;
    logic [19:0]     min_reg;
    logic [25:0]     max_reg;
    logic [31:0]     insert_reg;
    logic [63:0]     baseline_reg;
    logic [SCW-1:0]  scan_cnt_reg;
    logic [FCW-1:0]  fire_cnt_reg;
    logic            rm_valid_reg;
    logic [63:0]     rm_dl_reg;
    logic [25:0]     delay_reg;
    logic [25:0]     delay_next;
    logic            strobe_reg;
    out_item_t       out_reg;

    // control decoded from state
    slot_wr_t        wr;
    logic            emit;
    out_item_t       emit_item;
    logic            hist_inc;
    logic            bump_insert;
    logic            load_rearm;

    cand_t           chain [SLOTS];
    logic [SLOTS-1:0] done_vec;
    cand_t           head;
    logic            slot_ok;
    logic            at_head;
    logic            due;
    logic [31:0]     bin_count;
    logic [63:0]     diff;

    assign slot_ok = (32'(item_reg.slot) < SLOTS);
    assign head    = chain[SLOTS-1];
    assign at_head = !head.valid || (item_reg.deadline < head.deadline);
    assign due     = head.valid && (head.deadline <= item_reg.now) &&
                     (32'(fire_cnt_reg) < MAX_FIRES);

    // ---- slot cell chain: candidate ripples from cell 0 to cell SLOTS-1 ----
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        cand_t cin;
        if (i == 0)
        begin : g_first
            assign cin = '0;
        end
        else
        begin : g_rest
            assign cin = chain[i-1];
        end
        dcs_slot_cell #(.IDX(i)) u_cell
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .wr           (wr),
            .insert_count (insert_reg),
            .cand_in      (cin),
            .cand_out     (chain[i]),
            .done         (done_vec[i])
        );
    end

    dcs_hist u_hist
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .inc      (hist_inc),
        .lat      (16'(item_reg.now - baseline_reg)),
        .rd_bin   (item_reg.bin),
        .rd_count (bin_count)
    );

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (item_reg.command)
                    CMD_SCHEDULE: state_next = slot_ok ? ST_SCAN : ST_IDLE;
                    CMD_TICK:     state_next = ST_SCAN;
                    CMD_READ_BIN: state_next = ST_BINRD;
                    default:      state_next = ST_IDLE;
                endcase
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == SCW'(1))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (item_reg.command == CMD_SCHEDULE)
                begin
                    state_next = at_head ? ST_REARM : ST_IDLE;
                end
                else
                begin
                    state_next = due ? ST_SCAN : ST_REARM;
                end
            end
            ST_REARM:  state_next = ST_REPORT;
            ST_REPORT: state_next = ST_IDLE;
            ST_BINRD:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---- control outputs ----
    always_comb
    begin
        wr          = '0;
        wr.op       = WR_NONE;
        wr.idx      = '1;
        emit        = 1'b0;
        emit_item   = '0;
        hist_inc    = 1'b0;
        bump_insert = 1'b0;
        load_rearm  = 1'b0;
        case (state_reg)
            ST_EXEC:
            begin
                wr.idx    = IDX_W'(item_reg.slot);
                wr.period = item_reg.period;
                wr.notify = item_reg.notify;
                case (item_reg.command)
                    CMD_SCHEDULE:
                    begin
                        if (slot_ok)
                        begin
                            wr.op = WR_SETUP;
                        end
                        else
                        begin
                            emit                  = 1'b1;
                            emit_item.result_kind = KIND_COMPARE;
                            emit_item.last        = 1'b1;
                        end
                    end
                    CMD_CANCEL:
                    begin
                        if (slot_ok)
                        begin
                            wr.op = WR_CANCEL;
                        end
                    end
                    CMD_TICK:
                    begin
                        hist_inc = 1'b1;
                    end
                    CMD_QUERY:
                    begin
                        emit                  = 1'b1;
                        emit_item.result_kind = KIND_DONE;
                        emit_item.entry_done  = slot_ok ? done_vec[SW'(item_reg.slot)] : 1'b1;
                        emit_item.last        = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_DECIDE:
            begin
                wr.stamp = insert_reg;
                if (item_reg.command == CMD_SCHEDULE)
                begin
                    wr.op       = WR_ENTER;
                    wr.idx      = IDX_W'(item_reg.slot);
                    wr.deadline = item_reg.deadline;
                    bump_insert = 1'b1;
                    load_rearm  = at_head;
                    if (!at_head)
                    begin
                        emit                  = 1'b1;
                        emit_item.result_kind = KIND_COMPARE;
                        emit_item.last        = 1'b1;
                    end
                end
                else if (due)
                begin
                    wr.idx      = head.idx;
                    wr.deadline = head.deadline + 64'(head.period);
                    if (head.period != 32'd0)
                    begin
                        wr.op       = WR_ENTER;
                        bump_insert = 1'b1;
                    end
                    else
                    begin
                        wr.op = WR_EXPIRE;
                    end
                    if (head.notify)
                    begin
                        emit                  = 1'b1;
                        emit_item.result_kind = KIND_FIRE;
                        emit_item.fired_slot  = 4'(head.idx);
                    end
                end
                else
                begin
                    load_rearm = 1'b1;
                end
            end
            ST_REPORT:
            begin
                emit                    = 1'b1;
                emit_item.result_kind   = KIND_COMPARE;
                emit_item.timer_rearmed = 1'b1;
                emit_item.next_delay    = delay_reg;
                emit_item.last          = 1'b1;
            end
            ST_BINRD:
            begin
                emit                  = 1'b1;
                emit_item.result_kind = KIND_COUNT;
                emit_item.bin_count   = bin_count;
                emit_item.last        = 1'b1;
            end
            default: ;
        endcase
    end

    // compare delay from the head deadline
    assign diff = rm_dl_reg - item_reg.now;
    always_comb
    begin
        if (!rm_valid_reg)
        begin
            delay_next = max_reg;
        end
        else if (rm_dl_reg <= item_reg.now || diff <= 64'(min_reg))
        begin
            delay_next = 26'(min_reg);
        end
        else if (diff < 64'(max_reg))
        begin
            delay_next = diff[25:0];
        end
        else
        begin
            delay_next = max_reg;
        end
    end

    // ---- registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            min_reg      <= MIN_INTERVAL_RESET;
            max_reg      <= MAX_INTERVAL_RESET;
            insert_reg   <= 32'd0;
            baseline_reg <= 64'd0;
            scan_cnt_reg <= '0;
            fire_cnt_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= emit;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_MIN_INTERVAL: min_reg <= cfg_data[19:0];
                    CFG_MAX_INTERVAL: max_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (bump_insert)
            begin
                insert_reg <= insert_reg + 32'd1;
            end
            if (state_reg == ST_REPORT)
            begin
                baseline_reg <= item_reg.now + 64'(delay_reg);
            end
            if (state_next == ST_SCAN && state_reg != ST_SCAN)
            begin
                scan_cnt_reg <= SCW'(SLOTS);
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg - SCW'(1);
            end
            if (state_reg == ST_EXEC)
            begin
                fire_cnt_reg <= '0;
            end
            else if (state_reg == ST_DECIDE && item_reg.command == CMD_TICK && due)
            begin
                fire_cnt_reg <= fire_cnt_reg + FCW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            item_reg <= item;
        end
        if (load_rearm)
        begin
            rm_valid_reg <= (item_reg.command == CMD_SCHEDULE) ? 1'b1 : head.valid;
            rm_dl_reg    <= (item_reg.command == CMD_SCHEDULE) ? item_reg.deadline
                                                               : head.deadline;
        end
        if (state_reg == ST_REARM)
        begin
            delay_reg <= delay_next;
        end
        if (emit)
        begin
            out_reg <= emit_item;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign result_strobe = strobe_reg;
    assign result        = out_reg;

    // ---- assertions ----
    a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.result_kind == KIND_FIRE |-> !result.last)
        else $error("fire beat marked last");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_fire_limit: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fire_cnt_reg) <= MAX_FIRES)
        else $error("expiry count beyond limit");

    a_report_rearmed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_REPORT |=> result_strobe && result.timer_rearmed && result.last)
        else $error("compare report missing");

endmodule

// ===== bench/deadline_callout_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_callout_scheduler_tb
// Drives schedule, cancel, tick, query and histogram read commands into the
// callout scheduler and checks every result beat against a behavioral model
// of the slot table, the compare delay and the latency histogram.
// ----------------------------------------------------------------------------
module deadline_callout_scheduler_tb;
    import dcs_pkg::*;

    localparam int NSLOT     = 16;
    localparam int NFIRE     = 63;
    localparam int WDOG_MAX  = 20000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [25:0] cfg_data;
    logic        result_strobe;
    out_item_t   result;

    deadline_callout_scheduler u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .result        (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Model state of the timer table
    // ------------------------------------------------------------------
    logic [19:0] m_min_iv;
    logic [25:0] m_max_iv;
    logic        m_active   [NSLOT];
    logic        m_done     [NSLOT];
    logic [63:0] m_deadline [NSLOT];
    logic [31:0] m_period   [NSLOT];
    logic        m_notify   [NSLOT];
    logic [31:0] m_stamp    [NSLOT];
    logic [31:0] m_ins_cnt;
    logic [63:0] m_baseline;
    logic [31:0] m_hist     [HIST_ENTRIES];

    out_item_t   pending_beats [$];
    int          errors;
    int          wdog;
    int          idle_pct;
    bit          running;

    // slot at the head of the deadline order, -1 when the table is empty
    function automatic int head_of_queue();
        int best;
        best = -1;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (m_active[i])
            begin
                if (best < 0 || m_deadline[i] < m_deadline[best])
                    best = i;
                else if (m_deadline[i] == m_deadline[best] &&
                         (m_ins_cnt - m_stamp[i]) > (m_ins_cnt - m_stamp[best]))
                    best = i;
            end
        end
        return best;
    endfunction

    task automatic enter_entry(input int s, input logic [63:0] dl);
        m_deadline[s] = dl;
        m_stamp[s]    = m_ins_cnt;
        m_ins_cnt     = m_ins_cnt + 1;
        m_active[s]   = 1'b1;
        m_done[s]     = 1'b0;
    endtask

    function automatic logic [25:0] compute_delay(input logic [63:0] now);
        logic [63:0] d;
        logic [63:0] dl;
        int h;
        d = 64'(m_max_iv);
        h = head_of_queue();
        if (h >= 0)
        begin
            dl = m_deadline[h];
            if (dl <= now || dl - now <= 64'(m_min_iv))
                d = 64'(m_min_iv);
            else if (dl - now < 64'(m_max_iv))
                d = dl - now;
        end
        m_baseline = now + d;
        return d[25:0];
    endfunction

    function automatic out_item_t beat(input logic [1:0] k);
        out_item_t o;
        o = '0;
        o.result_kind = k;
        o.last = 1'b1;
        return o;
    endfunction

    // works out the beats of one accepted command and queues them
    task automatic predict_beats(input in_item_t it);
        out_item_t o;
        int s;
        int h;
        bit at_head;
        logic [15:0] lat;
        logic [63:0] old;
        s = int'(it.slot);
        case (it.command)
            CMD_SCHEDULE:
            begin
                o = beat(KIND_COMPARE);
                m_active[s] = 1'b0;
                m_period[s] = it.period;
                m_notify[s] = it.notify;
                h = head_of_queue();
                at_head = (h < 0) || (it.deadline < m_deadline[h]);
                enter_entry(s, it.deadline);
                if (at_head)
                begin
                    o.next_delay    = compute_delay(it.now);
                    o.timer_rearmed = 1'b1;
                end
                pending_beats.push_back(o);
            end
            CMD_CANCEL:
            begin
                m_active[s] = 1'b0;
                m_done[s]   = 1'b1;
                m_period[s] = '0;
            end
            CMD_TICK:
            begin
                lat = 16'(it.now - m_baseline);
                m_hist[latency_bin(lat)]++;
                for (int e = 0; e < NFIRE; e++)
                begin
                    h = head_of_queue();
                    if (h < 0 || m_deadline[h] > it.now)
                        break;
                    old = m_deadline[h];
                    m_active[h] = 1'b0;
                    m_done[h]   = 1'b1;
                    if (m_notify[h])
                    begin
                        o = beat(KIND_FIRE);
                        o.fired_slot = 4'(h);
                        o.last = 1'b0;
                        pending_beats.push_back(o);
                    end
                    if (m_period[h] != 0)
                        enter_entry(h, old + 64'(m_period[h]));
                end
                o = beat(KIND_COMPARE);
                o.timer_rearmed = 1'b1;
                o.next_delay = compute_delay(it.now);
                pending_beats.push_back(o);
            end
            CMD_QUERY:
            begin
                o = beat(KIND_DONE);
                o.entry_done = m_done[s];
                pending_beats.push_back(o);
            end
            CMD_READ_BIN:
            begin
                o = beat(KIND_COUNT);
                o.bin_count = (it.bin <= LATENCY_BINS) ? m_hist[it.bin] : '0;
                pending_beats.push_back(o);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result checker: sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t exp_b;
        if (rst_n && result_strobe)
        begin
            if (pending_beats.size() == 0)
            begin
                $display("%0t: unexpected beat %h", $time, result);
                errors++;
            end
            else
            begin
                exp_b = pending_beats.pop_front();
                if (result !== exp_b)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_b, result);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat of any kind
    always @(posedge clk)
    begin
        if (!running || (start && !busy) || result_strobe || (cfg_valid && cfg_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one command: random gap, then hold start until accepted
    task automatic send_cmd(input in_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        item  <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_beats(it);
        @(negedge clk);
    endtask

    task automatic drain();
        int n;
        n = 0;
        start <= 1'b0;
        while (pending_beats.size() != 0 && n < 50000)
        begin
            @(negedge clk);
            n++;
        end
        // cancel gives no beat; let the block settle
        repeat (400) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [25:0] val);
        drain();
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_MIN_INTERVAL)
            m_min_iv = val[19:0];
        else
            m_max_iv = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t mk(input logic [2:0] c, input int s,
                                    input logic [63:0] dl, input logic [31:0] p,
                                    input logic nt, input logic [63:0] nw,
                                    input logic [3:0] b);
        in_item_t it;
        it.command = c; it.slot = 4'(s); it.deadline = dl; it.period = p;
        it.notify = nt; it.now = nw; it.bin = b;
        return it;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // mostly well-formed traffic around a moving clock, some noise
    task automatic random_phase(input int n, inout logic [63:0] t);
        in_item_t it;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            it = mk(CMD_TICK, $urandom_range(15), 0, 0, $urandom_range(1), t,
                    $urandom_range(15));
            if (r < 35)
            begin
                it.command  = CMD_SCHEDULE;
                it.deadline = t + 64'($urandom_range(3000));
                it.period   = ($urandom_range(2) == 0) ? 32'd0 : 32'($urandom_range(500));
                if ($urandom_range(19) == 0)
                begin
                    it.deadline = rnd64();
                    it.period   = $urandom();
                end
            end
            else if (r < 45)
                it.command = CMD_CANCEL;
            else if (r < 75)
            begin
                t = t + 64'($urandom_range(1200));
                it.now = t;
            end
            else if (r < 87)
                it.command = CMD_QUERY;
            else if (r < 97)
                it.command = CMD_READ_BIN;
            else
            begin
                it.command = 3'($urandom_range(5, 7));
                it.now = rnd64();
            end
            if (it.command == CMD_TICK && $urandom_range(29) == 0)
                it.now = rnd64();
            send_cmd(it);
        end
    endtask

    typedef struct {
        in_item_t  it;
        bit        has_exp;
        out_item_t exp_b;
    } dir_row_t;

    initial
    begin
        dir_row_t    rows [$];
        dir_row_t    rw;
        out_item_t   tmp;
        logic [63:0] t;

        errors = 0; wdog = 0; idle_pct = 0; running = 0;
        rst_n = 1'b0; start = 1'b0; item = '0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        m_min_iv = MIN_INTERVAL_RESET; m_max_iv = MAX_INTERVAL_RESET;
        for (int i = 0; i < NSLOT; i++)
        begin
            m_active[i] = 0; m_done[i] = 1; m_deadline[i] = 0;
            m_period[i] = 0; m_notify[i] = 0; m_stamp[i] = 0;
        end
        for (int i = 0; i < HIST_ENTRIES; i++)
            m_hist[i] = 0;
        m_ins_cnt = 0; m_baseline = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        running = 1;
        @(negedge clk);

        // directed table: after-reset reads and simple rows carry a typed result
        tmp = beat(KIND_DONE); tmp.entry_done = 1'b1;
        rows.push_back('{mk(CMD_QUERY, 0, 0, 0, 0, 0, 0), 1, tmp});
        rows.push_back('{mk(CMD_QUERY, 15, 0, 0, 0, 0, 0), 1, tmp});
        tmp = beat(KIND_COUNT);
        rows.push_back('{mk(CMD_READ_BIN, 0, 0, 0, 0, 0, 0), 1, tmp});
        rows.push_back('{mk(CMD_READ_BIN, 0, 0, 0, 0, 0, 15), 1, tmp});
        // empty table tick at time 0: histogram bin 0, delay max_interval
        tmp = beat(KIND_COMPARE); tmp.timer_rearmed = 1; tmp.next_delay = 26'd50000000;
        rows.push_back('{mk(CMD_TICK, 0, 0, 0, 0, 0, 0), 1, tmp});
        tmp = beat(KIND_COUNT); tmp.bin_count = 1;
        rows.push_back('{mk(CMD_READ_BIN, 0, 0, 0, 0, 0, 0), 1, tmp});
        rows.push_back('{mk(CMD_SCHEDULE, 3, 100, 0, 1, 0, 0), 0, tmp});
        rows.push_back('{mk(CMD_SCHEDULE, 5, 100, 0, 1, 0, 0), 0, tmp});   // tie, younger
        rows.push_back('{mk(CMD_SCHEDULE, 7, 40, 10, 1, 20, 0), 0, tmp});  // due within min
        rows.push_back('{mk(CMD_SCHEDULE, 9, 80, 0, 0, 20, 0), 0, tmp});   // silent expiry
        rows.push_back('{mk(CMD_SCHEDULE, 0, '1, '1, 1, 0, 0), 0, tmp});
        rows.push_back('{mk(CMD_QUERY, 3, 0, 0, 0, 0, 0), 0, tmp});
        rows.push_back('{mk(CMD_TICK, 0, 0, 0, 0, 120, 0), 0, tmp});
        rows.push_back('{mk(CMD_QUERY, 3, 0, 0, 0, 0, 0), 0, tmp});
        rows.push_back('{mk(CMD_CANCEL, 7, 0, 0, 0, 0, 0), 0, tmp});
        rows.push_back('{mk(CMD_TICK, 0, 0, 0, 0, '1, 0), 0, tmp});        // periodic wrap
        rows.push_back('{mk(CMD_CANCEL, 0, 0, 0, 0, 0, 0), 0, tmp});
        rows.push_back('{mk(3'd7, 15, '1, '1, 1, '1, 15), 0, tmp});        // unknown command
        for (int i = 0; i <= HIST_ENTRIES; i++)
            rows.push_back('{mk(CMD_READ_BIN, 0, 0, 0, 0, 0, 4'(i)), 0, tmp});

        foreach (rows[i])
        begin
            rw = rows[i];
            send_cmd(rw.it);
            // typed-in results are checked against the model's for the simple rows
            if (rw.has_exp && pending_beats.size() != 0 &&
                pending_beats[$] !== rw.exp_b)
            begin
                $display("%0t: table row %0d expected %h model %h", $time, i,
                         rw.exp_b, pending_beats[$]);
                errors++;
            end
        end

        // random phases with varying sender idling and register settings
        t = 64'd1000;
        write_cfg(CFG_MIN_INTERVAL, 26'd1);
        write_cfg(CFG_MAX_INTERVAL, 26'h3FFFFFF);
        idle_pct = 0;  random_phase(60, t);
        write_cfg(CFG_MIN_INTERVAL, 26'd1000000);
        write_cfg(CFG_MAX_INTERVAL, 26'd1);
        idle_pct = 65; random_phase(60, t);
        write_cfg(CFG_MIN_INTERVAL, 26'd20);
        write_cfg(CFG_MAX_INTERVAL, 26'd700);
        idle_pct = 14; random_phase(70, t);
        write_cfg(CFG_MIN_INTERVAL, 26'($urandom_range(1, 1000000)));
        write_cfg(CFG_MAX_INTERVAL, 26'($urandom_range(1, 2000)));
        idle_pct = 40; random_phase(60, t);

        drain();
        running = 0;
        if (errors == 0 && pending_beats.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
